FILE: hw/rtl/sta_pkg.sv
// Shared types and codes for the sighting table with aging.
`timescale 1ns / 1ps
package sta_pkg;

  localparam logic [1:0] ACT_SIGHT = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_LIST  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [1:0] CFG_STALE   = 2'd0;
  localparam logic [1:0] CFG_RECENT  = 2'd1;
  localparam logic [1:0] CFG_PERSIST = 2'd2;

  localparam logic [15:0] COUNT_SAT = 16'hFFFF;
  localparam logic [5:0]  SUM_SAT   = 6'd63;

  typedef struct packed {
    logic [47:0] addr;
    logic [7:0]  kind;
    logic [7:0]  strength;
    logic [15:0] count;
    logic [31:0] first;
    logic [31:0] last;
  } slot_t;

endpackage

FILE: hw/rtl/sighting_table_with_aging.sv
// Top level: sighting table held in a one-port-write, one-port-read memory.
// Each item is accepted only after the previous one finishes: a sighting scans stored
//   addresses, a tick scans every entry, a list copies and sorts before its results.
// Throughput: one item at a time; the memory read port (one read per cycle, registered
//   read data) has each scan alternate a read and a check; output stalls can also hold an item.
// Reset: rst is synchronous, active high; clears occupancy, control state and
//   restores the limit registers; table contents stay undefined until written.
`timescale 1ns / 1ps
module sighting_table_with_aging #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [47:0] device_address,
  input  logic [7:0]  device_kind,
  input  logic signed [7:0] signal_strength,
  input  logic [31:0] time_ms,
  input  logic [5:0]  list_limit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [5:0]  nearby_count,
  output logic [5:0]  persistent_count,
  output logic        alert_flag,
  output logic        entry_valid,
  output logic [47:0] entry_address,
  output logic [7:0]  entry_kind,
  output logic signed [7:0] entry_strength,
  output logic [15:0] entry_sightings,
  output logic [31:0] entry_first_ms,
  output logic [31:0] entry_last_ms,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = 6; // list buffer holds up to 32 entries
  localparam int LDEPTH = 32;
  localparam int NW = (CW > LW) ? CW : LW;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SRCH  = 11'b00000000010, // sighting: scan addresses
    S_TSCAN = 11'b00000000100, // tick: compact and count
    S_TOUT  = 11'b00000001000,
    S_LLOAD = 11'b00000010000, // list: copy into sort buffer
    S_SRDI  = 11'b00000100000, // sort: read element i
    S_SRDJ  = 11'b00001000000, // sort: compare with element j
    S_SWAP  = 11'b00010000000, // sort: write element j into slot i
    S_SWAP2 = 11'b00100000000, // sort: write old element i into slot j
    S_LOUT  = 11'b01000000000,
    S_LWAIT = 11'b10000000000
  } state_t;

  state_t state;
  logic [31:0] stale_lim, recent_lim, persist_lim;
  logic [CW-1:0] occ;

  // Held request.
  logic [1:0]  req_act;
  sta_pkg::slot_t req;
  logic [5:0]  req_limit;

  // Table memory.
  sta_pkg::slot_t mem [MAX_ENTRIES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  sta_pkg::slot_t mem_wdata, mem_rdata;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  // Sort buffer memory.
  sta_pkg::slot_t lbuf [LDEPTH];
  logic          lb_we;
  logic [4:0]    lb_waddr, lb_raddr;
  sta_pkg::slot_t lb_wdata, lb_rdata;
  always_ff @(posedge clk) begin
    if (lb_we) lbuf[lb_waddr] <= lb_wdata;
    lb_rdata <= lbuf[lb_raddr];
  end

  // Scan counters: ch_idx addresses the read, pend marks data returning next cycle.
  logic [CW-1:0] ch_idx, wr_idx;
  logic          pend;
  logic [5:0]    near_cnt, pers_cnt;
  logic [LW-1:0] n_list, si, sj;
  sta_pkg::slot_t held_i, swap_j;

  // Output register.
  logic ov;
  logic emit;
  sta_pkg::slot_t o_slot;
  logic o_kind, o_alert, o_evalid, o_last;
  logic [5:0] o_near, o_pers;

  assign in_stall = (state != S_IDLE);
  wire in_fire  = in_valid && !in_stall;
  wire out_free = !ov || !out_stall;

  logic [NW-1:0] list_n;
  always_comb begin
    list_n = (NW'(req_limit) < NW'(occ)) ? NW'(req_limit) : NW'(occ);
    if (NW'(LDEPTH) < list_n) list_n = NW'(LDEPTH);
  end

  wire [31:0] age    = req.first - mem_rdata.last;   // req.first carries now
  wire [31:0] lived  = mem_rdata.last - mem_rdata.first;
  wire        stale  = age > stale_lim;
  wire        recent = age < recent_lim;
  wire        jstrong = $signed(lb_rdata.strength) > $signed(held_i.strength);

  // Memory port drive.
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = wr_idx[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = ch_idx[AW-1:0];
    lb_we = 1'b0;
    lb_waddr = 5'(ch_idx);
    lb_wdata = mem_rdata;
    lb_raddr = 5'(si);
    unique case (state)
      S_SRCH: begin
        if (pend && mem_rdata.addr == req.addr) begin
          mem_we = 1'b1;
          mem_waddr = ch_idx[AW-1:0];
          mem_wdata = mem_rdata;
          if (mem_rdata.count != sta_pkg::COUNT_SAT) mem_wdata.count = mem_rdata.count + 16'd1;
          mem_wdata.kind = req.kind;
          mem_wdata.strength = req.strength;
          mem_wdata.last = req.last;
        end else if (!pend && ch_idx >= occ && occ < CW'(MAX_ENTRIES)) begin
          mem_we = 1'b1;
          mem_waddr = occ[AW-1:0];
          mem_wdata = req;
        end
      end
      S_TSCAN: begin
        if (pend && !stale) mem_we = 1'b1;
      end
      S_LLOAD: lb_we = pend;
      S_SRDI:  lb_raddr = 5'(si);
      S_SRDJ:  lb_raddr = 5'(sj);
      S_SWAP: begin
        lb_we = 1'b1;
        lb_waddr = 5'(si);
        lb_wdata = swap_j;
      end
      S_SWAP2: begin
        lb_we = 1'b1;
        lb_waddr = 5'(sj);
        lb_wdata = held_i;
      end
      S_LOUT:  lb_raddr = 5'(si);
      default: ;
    endcase
  end

  // Load the output register whenever a result is ready and the slot is free.
  always_comb begin
    emit = out_free && ((state == S_TOUT) || (state == S_LWAIT) ||
                        (state == S_LOUT && pend));
  end

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else ov <= (ov && out_stall) || emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stale_lim <= 32'd60000;
      recent_lim <= 32'd10000;
      persist_lim <= 32'd300000;
      occ <= '0;
      pend <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sta_pkg::CFG_STALE:   stale_lim <= cfg_data;
          sta_pkg::CFG_RECENT:  recent_lim <= cfg_data;
          sta_pkg::CFG_PERSIST: persist_lim <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          ch_idx <= '0;
          wr_idx <= '0;
          near_cnt <= '0;
          pers_cnt <= '0;
          if (in_fire) begin
            req_act <= action;
            req.addr <= device_address;
            req.kind <= device_kind;
            req.strength <= signal_strength;
            req.count <= 16'd1;
            req.first <= time_ms;
            req.last <= time_ms;
            req_limit <= list_limit;
            unique case (action)
              sta_pkg::ACT_SIGHT: state <= S_SRCH;
              sta_pkg::ACT_TICK:  state <= S_TSCAN;
              sta_pkg::ACT_LIST:  state <= S_LLOAD;
              sta_pkg::ACT_CLEAR: occ <= '0;
              default: ;
            endcase
          end
        end
        S_SRCH: begin
          // Alternate issue and check so a hit ends the scan cleanly.
          if (pend) begin
            pend <= 1'b0;
            if (mem_rdata.addr == req.addr) state <= S_IDLE;
            else ch_idx <= ch_idx + 1'b1;
          end else if (ch_idx >= occ) begin
            if (occ < CW'(MAX_ENTRIES)) occ <= occ + 1'b1;
            state <= S_IDLE;
          end else begin
            pend <= 1'b1;
          end
        end
        S_TSCAN: begin
          if (pend) begin
            pend <= 1'b0;
            ch_idx <= ch_idx + 1'b1;
            if (!stale) begin
              wr_idx <= wr_idx + 1'b1;
              if (recent && near_cnt != sta_pkg::SUM_SAT) near_cnt <= near_cnt + 6'd1;
              if (recent && lived > persist_lim && pers_cnt != sta_pkg::SUM_SAT)
                pers_cnt <= pers_cnt + 6'd1;
            end
          end else if (ch_idx >= occ) begin
            occ <= wr_idx;
            state <= S_TOUT;
          end else begin
            pend <= 1'b1;
          end
        end
        S_TOUT: begin
          if (out_free) begin
            o_kind <= 1'b0;
            o_near <= near_cnt;
            o_pers <= pers_cnt;
            o_alert <= (pers_cnt != 6'd0);
            o_evalid <= 1'b0;
            o_slot <= '0;
            o_last <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_LLOAD: begin
          if (pend) begin
            pend <= 1'b0;
            ch_idx <= ch_idx + 1'b1;
          end else if (NW'(ch_idx) >= list_n) begin
            n_list <= LW'(list_n);
            si <= '0;
            if (list_n == '0) state <= S_LWAIT;
            else state <= S_SRDI;
          end else begin
            pend <= 1'b1;
          end
        end
        S_SRDI: begin
          // pend low: read of element i issued; pend high: hold element i.
          if (!pend) begin
            if (si + 6'd1 >= n_list) begin
              si <= '0;
              state <= S_LOUT;
            end else begin
              pend <= 1'b1;
            end
          end else begin
            held_i <= lb_rdata;
            sj <= si + 6'd1;
            pend <= 1'b0;
            state <= S_SRDJ;
          end
        end
        S_SRDJ: begin
          // pend low: read of element j issued; pend high: compare with element i.
          if (!pend) begin
            pend <= 1'b1;
          end else if (jstrong) begin
            swap_j <= lb_rdata;
            state <= S_SWAP;
          end else if (sj + 6'd1 >= n_list) begin
            si <= si + 6'd1;
            pend <= 1'b0;
            state <= S_SRDI;
          end else begin
            sj <= sj + 6'd1;
            pend <= 1'b0;
          end
        end
        S_SWAP: state <= S_SWAP2;
        S_SWAP2: begin
          // Element j now sits at i; keep it as the running element i.
          held_i <= swap_j;
          pend <= 1'b0;
          if (sj + 6'd1 >= n_list) begin
            si <= si + 6'd1;
            state <= S_SRDI;
          end else begin
            sj <= sj + 6'd1;
            state <= S_SRDJ;
          end
        end
        S_LOUT: begin
          // pend low: read issued; pend high: data present, emit.
          if (!pend) pend <= 1'b1;
          else if (out_free) begin
            o_kind <= 1'b1;
            o_near <= '0;
            o_pers <= '0;
            o_alert <= 1'b0;
            o_evalid <= 1'b1;
            o_slot <= lb_rdata;
            o_last <= (si + 6'd1 == n_list);
            pend <= 1'b0;
            if (si + 6'd1 == n_list) state <= S_IDLE;
            else si <= si + 6'd1;
          end
        end
        S_LWAIT: begin
          if (out_free) begin
            o_kind <= 1'b1;
            o_near <= '0;
            o_pers <= '0;
            o_alert <= 1'b0;
            o_evalid <= 1'b0;
            o_slot <= '0;
            o_last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = ov;
  assign result_kind      = o_kind;
  assign nearby_count     = o_near;
  assign persistent_count = o_pers;
  assign alert_flag       = o_alert;
  assign entry_valid      = o_evalid;
  assign entry_address    = o_slot.addr;
  assign entry_kind       = o_slot.kind;
  assign entry_strength   = o_slot.strength;
  assign entry_sightings  = o_slot.count;
  assign entry_first_ms   = o_slot.first;
  assign entry_last_ms    = o_slot.last;
  assign last_of_run      = o_last;

endmodule

FILE: hw/rtl/sta_checker.sv
// Port-level checker for the sighting table, bound to the top level.
`timescale 1ns / 1ps
module sta_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       result_kind,
  input logic       entry_valid,
  input logic       last_of_run,
  input logic       alert_flag,
  input logic [5:0] persistent_count,
  input logic [5:0] nearby_count
);
  a_alert: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (alert_flag == (persistent_count != 6'd0)))
    else $error("alert flag disagrees with persistent count");
  a_pers: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_kind |-> persistent_count <= nearby_count)
    else $error("persistent count above nearby count");
  a_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_kind |-> !entry_valid && !last_of_run)
    else $error("tick summary carries list fields");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");
endmodule

bind sighting_table_with_aging sta_checker u_sta_checker (.*);
